// ===== rtl/core/tolerant_gesture_sequence_matcher_unit_macros.svh =====
// Assertion macros for the gesture matcher unit.
// Expect clk_i and rst_ni in the scope of the user; no other dependencies.
`ifndef TOLERANT_GESTURE_SEQUENCE_MATCHER_UNIT_MACROS_SVH
`define TOLERANT_GESTURE_SEQUENCE_MATCHER_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define TGSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TGSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tgsm_pkg.sv =====
// Package of the gesture matcher unit: sizes, codes, word types, match function.
// No dependencies.
package tgsm_pkg;

  localparam int MAX_GESTURES = 16;
  localparam int MAX_STEPS    = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int FINGERS      = 5;

  localparam int GEST_W     = (MAX_GESTURES > 1) ? $clog2(MAX_GESTURES) : 1;
  localparam int STEP_IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int CNT_W      = $clog2(MAX_GESTURES + 1);
  localparam int ADDR_W     = GEST_W + STEP_IDX_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  localparam int SNAP_W     = FINGERS * SAMPLE_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 50;
  localparam int GCOUNT_W   = 5;
  localparam int MASK_W     = 16;
  localparam int REC_W      = 4;

  localparam logic [SAMPLE_BITS-1:0] TOL_RESET = SAMPLE_BITS'(64);

  typedef enum logic [2:0] {
    CMD_WR_STEP   = 3'd0,
    CMD_WR_LEN    = 3'd1,
    CMD_START     = 3'd2,
    CMD_SAMPLE    = 3'd3,
    CMD_ACT_CHECK = 3'd4
  } tgsm_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOL_1   = 3'd0,
    REG_TOL_2   = 3'd1,
    REG_TOL_3   = 3'd2,
    REG_TOL_4   = 3'd3,
    REG_TOL_5   = 3'd4,
    REG_ACT_PAT = 3'd5,
    REG_GCOUNT  = 3'd6
  } tgsm_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } tgsm_state_e;

  typedef logic [SNAP_W-1:0] tgsm_snap_t;
  typedef logic [FINGERS-1:0][SAMPLE_BITS-1:0] tgsm_tol_t;

  typedef struct packed {
    logic [2:0]             command;
    logic [3:0]             gesture_index;
    logic [2:0]             step_index;
    logic [3:0]             step_count;
    logic [SAMPLE_BITS-1:0] finger_one;
    logic [SAMPLE_BITS-1:0] finger_two;
    logic [SAMPLE_BITS-1:0] finger_three;
    logic [SAMPLE_BITS-1:0] finger_four;
    logic [SAMPLE_BITS-1:0] finger_five;
  } tgsm_in_t;

  typedef struct packed {
    logic              recognized;
    logic [REC_W-1:0]  recognized_gesture;
    logic [MASK_W-1:0] recognized_mask;
    logic              no_match;
    logic              session_running;
    logic              activation_match;
  } tgsm_out_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic              load;
    logic              exec;
    logic              rd_en;
    logic [GEST_W-1:0] rd_idx;
    logic              finish;
  } tgsm_ctl_t;

  // All five fingers must pass; a zero sample finger always passes.
  function automatic logic snap_match(input tgsm_snap_t smp, input tgsm_snap_t tpl,
                                      input tgsm_tol_t tol);
    logic                   ok;
    logic [SAMPLE_BITS-1:0] a;
    logic [SAMPLE_BITS-1:0] b;
    logic [SAMPLE_BITS-1:0] d;
    ok = 1'b1;
    for (int f = 0; f < FINGERS; f++) begin
      a  = smp[f*SAMPLE_BITS +: SAMPLE_BITS];
      b  = tpl[f*SAMPLE_BITS +: SAMPLE_BITS];
      d  = (a > b) ? (a - b) : (b - a);
      ok = ok & ((a == '0) | (d <= tol[f]));
    end
    return ok;
  endfunction

endpackage

// ===== rtl/core/tolerant_gesture_sequence_matcher_unit.sv =====
// Top level of the tolerant gesture sequence matcher.
// Depends on tgsm_pkg, tgsm_ctrl, tgsm_dp and the assertion macro header.
//
//   channel   handshake                       word
//   --------  ------------------------------  -----------------------------------
//   command   start_i & !busy_o               in_i  (tgsm_in_t)
//   result    done_o, one cycle, no stall     res_o (tgsm_out_t)
//   config    cfg_valid_i & cfg_ready_o       cfg_index_i, cfg_data_i
//
// Template writes, length writes, session start, activation check, unknown
// commands and a sample with no open session end in the decode state.
// A sample in an open session walks every gesture slot through the one read port
// of the template memory, one slot a cycle, then passes the drain and finish states
// before its result shows; a new word may be accepted while it shows. Reset
// clears config and session state, not the template memory; the receiver cannot stall.
`include "tolerant_gesture_sequence_matcher_unit_macros.svh"

module tolerant_gesture_sequence_matcher_unit import tgsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command word
  input  logic                  start_i,
  output logic                  busy_o,
  input  tgsm_in_t              in_i,
  // result word
  output logic                  done_o,
  output tgsm_out_t             res_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  tgsm_ctl_t ctl;
  logic      walk_req;

  // Config registers sit in flops; a write always lands at once.
  assign cfg_ready_o = 1'b1;

  // Sequencer: latch the word, decode, walk the gesture slots, finish.
  tgsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .walk_req_i (walk_req),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .ctl_o      (ctl)
  );

  // Datapath: template memory, per-gesture step and alive state, compare.
  tgsm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ctl_i       (ctl),
    .walk_req_o  (walk_req),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // The result is shown only once the sequencer is back to idle.
  `TGSM_ASSERT_SAME(a_done_idle, done_o, !busy_o, "result shown while busy")
  // Each word gets exactly one strobe.
  `TGSM_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe repeated")
  // A recognition and a no-match never come together.
  `TGSM_ASSERT_SAME(a_rec_excl, done_o && res_o.recognized, !res_o.no_match,
                    "recognized and no_match both set")
  // A recognition closes the session and names at least one gesture.
  `TGSM_ASSERT_SAME(a_rec_close, done_o && res_o.recognized,
                    !res_o.session_running && (res_o.recognized_mask != '0),
                    "recognition left session open or mask empty")

endmodule

// ===== rtl/core/tgsm_ctrl.sv =====
// Sequencer of the gesture matcher: decode, gesture walk, finish, result strobe.
// Depends on tgsm_pkg.
module tgsm_ctrl import tgsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      walk_req_i,
  output logic      busy_o,
  output logic      done_o,
  output tgsm_ctl_t ctl_o
);

  tgsm_state_e       state_q, state_d;
  logic [GEST_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              last_gest;

  assign last_gest = (cnt_q == GEST_W'(MAX_GESTURES - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_DECODE;
      ST_DECODE: state_d = walk_req_i ? ST_WALK : ST_IDLE;
      ST_WALK:   if (last_gest) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o        = '0;
    ctl_o.rd_idx = cnt_q;
    busy_o       = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:   ctl_o.load   = start_i;
      ST_DECODE: ctl_o.exec   = !walk_req_i;
      ST_WALK:   ctl_o.rd_en  = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: ctl_o.finish = 1'b1;
      default:   ;
    endcase
  end

  assign cnt_d  = ((state_q == ST_WALK) && !last_gest) ? cnt_q + 1'b1 : '0;
  assign done_d = ctl_o.exec | ctl_o.finish;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== rtl/core/tgsm_dp.sv =====
// Datapath of the gesture matcher: config registers, template memory,
// per-gesture session state, compare stage and result register. Depends on tgsm_pkg.
module tgsm_dp import tgsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tgsm_in_t              in_i,
  input  tgsm_ctl_t             ctl_i,
  output logic                  walk_req_o,
  output tgsm_out_t             res_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration
  tgsm_tol_t            tol_q;
  tgsm_snap_t           act_pat_q;
  logic [GCOUNT_W-1:0]  gcount_q;

  // latched input word
  tgsm_in_t             in_q;
  tgsm_cmd_e            cmd;
  tgsm_snap_t           smp;

  // session state
  logic [STEP_W-1:0]       len_q  [MAX_GESTURES];
  logic [STEP_W-1:0]       step_q [MAX_GESTURES];
  logic [MAX_GESTURES-1:0] alive_q;
  logic                    session_q, session_d;
  logic [MAX_GESTURES-1:0] mask_q;
  logic [GEST_W-1:0]       rec_q;
  logic                    any_q;

  // template memory and compare stage
  tgsm_snap_t              mem [MEM_DEPTH];
  tgsm_snap_t              rd_data_q;
  logic                    cmp_vld_q;
  logic [GEST_W-1:0]       cmp_idx_q;
  logic [STEP_IDX_W-1:0]   st_q;
  logic [STEP_IDX_W-1:0]   st_iss;
  logic                    mem_we;
  logic [ADDR_W-1:0]       wr_addr;
  logic                    wr_ok;
  logic [GEST_W-1:0]       wr_gest;

  logic [CNT_W-1:0]        n_gest;
  logic [MAX_GESTURES-1:0] start_alive;
  logic [STEP_W-1:0]       len_sat;
  logic                    cmp_hit;
  logic [STEP_W-1:0]       st_nxt;
  logic                    gest_done;
  tgsm_out_t               res_d, res_q;

  assign cmd     = tgsm_cmd_e'(in_q.command);
  assign smp     = {in_q.finger_five, in_q.finger_four, in_q.finger_three,
                    in_q.finger_two, in_q.finger_one};
  assign wr_gest = in_q.gesture_index[GEST_W-1:0];

  assign walk_req_o = (cmd == CMD_SAMPLE) && session_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < FINGERS; f++) tol_q[f] <= TOL_RESET;
      act_pat_q <= '0;
      gcount_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TOL_1, REG_TOL_2, REG_TOL_3, REG_TOL_4, REG_TOL_5:
          tol_q[cfg_index_i] <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_ACT_PAT: act_pat_q <= cfg_data_i[SNAP_W-1:0];
        REG_GCOUNT:  gcount_q  <= cfg_data_i[GCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) in_q <= in_i;
  end

  // template memory: one write port, one registered read port
  assign wr_ok   = (int'(in_q.gesture_index) < MAX_GESTURES) &&
                   (int'(in_q.step_index) < MAX_STEPS);
  assign mem_we  = ctl_i.exec && (cmd == CMD_WR_STEP) && wr_ok;
  assign wr_addr = {wr_gest, in_q.step_index[STEP_IDX_W-1:0]};
  assign st_iss  = (int'(step_q[ctl_i.rd_idx]) >= MAX_STEPS) ?
                   STEP_IDX_W'(MAX_STEPS - 1) : step_q[ctl_i.rd_idx][STEP_IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= smp;
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[{ctl_i.rd_idx, st_iss}];
      cmp_idx_q <= ctl_i.rd_idx;
      st_q      <= st_iss;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cmp_vld_q <= 1'b0;
    else         cmp_vld_q <= ctl_i.rd_en;
  end

  // start and length helpers
  assign n_gest  = (int'(gcount_q) > MAX_GESTURES) ? CNT_W'(MAX_GESTURES) : CNT_W'(gcount_q);
  assign len_sat = (int'(in_q.step_count) > MAX_STEPS) ? STEP_W'(MAX_STEPS)
                                                       : STEP_W'(in_q.step_count);
  always_comb begin
    for (int i = 0; i < MAX_GESTURES; i++) begin
      start_alive[i] = (CNT_W'(i) < n_gest) && (len_q[i] != '0);
    end
  end

  // compare stage
  assign cmp_hit   = snap_match(smp, rd_data_q, tol_q);
  assign st_nxt    = STEP_W'(st_q) + STEP_W'(1);
  assign gest_done = (st_nxt >= len_q[cmp_idx_q]);

  // result of the item
  always_comb begin
    res_d     = '0;
    session_d = session_q;
    if (ctl_i.exec) begin
      unique case (cmd)
        CMD_START: begin
          session_d      = |start_alive;
          res_d.no_match = ~|start_alive;
        end
        CMD_ACT_CHECK: res_d.activation_match = snap_match(smp, act_pat_q, tol_q);
        default: ;
      endcase
    end
    if (ctl_i.finish) begin
      if (|mask_q) begin
        res_d.recognized         = 1'b1;
        res_d.recognized_gesture = REC_W'(rec_q);
        res_d.recognized_mask    = MASK_W'(mask_q);
        session_d                = 1'b0;
      end else if (!any_q) begin
        res_d.no_match = 1'b1;
        session_d      = 1'b0;
      end
    end
    res_d.session_running = session_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec || ctl_i.finish) res_q <= res_d;
  end
  assign res_o = res_q;

  // session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_GESTURES; i++) begin
        len_q[i]  <= '0;
        step_q[i] <= '0;
      end
      alive_q   <= '0;
      session_q <= 1'b0;
      mask_q    <= '0;
      rec_q     <= '0;
      any_q     <= 1'b0;
    end else begin
      session_q <= session_d;
      if (ctl_i.load) begin
        mask_q <= '0;
        rec_q  <= '0;
        any_q  <= 1'b0;
      end
      if (ctl_i.exec && (cmd == CMD_WR_LEN) && (int'(in_q.gesture_index) < MAX_GESTURES)) begin
        len_q[wr_gest] <= len_sat;
      end
      if (ctl_i.exec && (cmd == CMD_START)) begin
        for (int i = 0; i < MAX_GESTURES; i++) step_q[i] <= '0;
        alive_q <= start_alive;
      end
      // advance or drop the gesture under compare
      if (cmp_vld_q && alive_q[cmp_idx_q]) begin
        if (cmp_hit) begin
          step_q[cmp_idx_q] <= st_nxt;
          if (gest_done) begin
            if (mask_q == '0) rec_q <= cmp_idx_q;
            mask_q[cmp_idx_q]  <= 1'b1;
            alive_q[cmp_idx_q] <= 1'b0;
          end else begin
            any_q <= 1'b1;
          end
        end else begin
          alive_q[cmp_idx_q] <= 1'b0;
        end
      end
      if (ctl_i.finish && (|mask_q)) alive_q <= '0;
    end
  end

endmodule

// ===== bench/tgsm_outcome_checker.sv =====
// Outcome checker for the gesture matcher unit: mirrors the template store, gesture
// lengths, session state and config registers, predicts every result word and compares.
// Depends on tgsm_pkg only.
module tgsm_outcome_checker import tgsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  tgsm_in_t              word_i,
  input  logic                  done_i,
  input  tgsm_out_t             res_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    faults_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    recognized_o,
  output int                    eliminated_o,
  output int                    act_hits_o
);

  typedef logic [FINGERS-1:0][SAMPLE_BITS-1:0] hand_t;

  localparam int REPORT_MAX = 10;

  hand_t     tpl_mem [MAX_GESTURES*MAX_STEPS];
  int        len_q   [MAX_GESTURES];
  int        pos_q   [MAX_GESTURES];
  logic      alive_q [MAX_GESTURES];
  logic      open_q;
  hand_t     tol_q;
  hand_t     act_q;
  int        gcount_q;
  tgsm_out_t outcome_q [$];

  function automatic hand_t hand_of(input tgsm_in_t w);
    return {w.finger_five, w.finger_four, w.finger_three, w.finger_two, w.finger_one};
  endfunction

  // A zero finger is a dead sensor and always passes.
  function automatic logic hand_fits(input hand_t smp, input hand_t tpl);
    int a;
    int b;
    int d;
    for (int f = 0; f < FINGERS; f++) begin
      a = smp[f];
      b = tpl[f];
      d = (a > b) ? a - b : b - a;
      if (a != 0 && d > int'(tol_q[f])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one command word to the mirrored state and return the result it causes.
  function automatic tgsm_out_t match_outcome(input tgsm_in_t w);
    tgsm_out_t o;
    hand_t     smp;
    int        n;
    int        st;
    logic      still;
    o     = '0;
    smp   = hand_of(w);
    still = 1'b0;
    unique case (w.command)
      CMD_WR_STEP: tpl_mem[w.gesture_index * MAX_STEPS + w.step_index] = smp;
      CMD_WR_LEN:  len_q[w.gesture_index] = (w.step_count > MAX_STEPS) ? MAX_STEPS
                                                                      : w.step_count;
      CMD_START: begin
        n = (gcount_q > MAX_GESTURES) ? MAX_GESTURES : gcount_q;
        for (int i = 0; i < MAX_GESTURES; i++) begin
          pos_q[i]   = 0;
          alive_q[i] = (i < n) && (len_q[i] != 0);
          still      = still | alive_q[i];
        end
        open_q     = still;
        o.no_match = !still;
      end
      CMD_SAMPLE: begin
        if (open_q) begin
          for (int i = 0; i < MAX_GESTURES; i++) begin
            if (alive_q[i]) begin
              st = (pos_q[i] >= MAX_STEPS) ? MAX_STEPS - 1 : pos_q[i];
              if (hand_fits(smp, tpl_mem[i * MAX_STEPS + st])) begin
                pos_q[i] = st + 1;
                if (pos_q[i] >= len_q[i]) begin
                  if (o.recognized_mask == '0) o.recognized_gesture = REC_W'(i);
                  o.recognized_mask[i] = 1'b1;
                  alive_q[i]           = 1'b0;
                end else begin
                  still = 1'b1;
                end
              end else begin
                alive_q[i] = 1'b0;
              end
            end
          end
          if (o.recognized_mask != '0) begin
            o.recognized = 1'b1;
            for (int i = 0; i < MAX_GESTURES; i++) alive_q[i] = 1'b0;
            open_q = 1'b0;
          end else if (!still) begin
            o.no_match = 1'b1;
            open_q     = 1'b0;
          end
        end
      end
      CMD_ACT_CHECK: o.activation_match = hand_fits(smp, act_q);
      default: ;
    endcase
    o.session_running = open_q;
    return o;
  endfunction

  task automatic note_fault(input string msg);
    faults_o++;
    if (faults_o <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tgsm_out_t want;
    string     bad;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_GESTURES; i++) begin
        len_q[i]   = 0;
        pos_q[i]   = 0;
        alive_q[i] = 1'b0;
      end
      open_q       = 1'b0;
      tol_q        = {FINGERS{TOL_RESET}};
      act_q        = '0;
      gcount_q     = 0;
      outcome_q.delete();
      faults_o     = 0;
      checked_o    = 0;
      recognized_o = 0;
      eliminated_o = 0;
      act_hits_o   = 0;
    end else begin
      // Retire the result first: it belongs to a word accepted earlier.
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          note_fault($sformatf("result word %h with no command waiting", res_i));
        end else begin
          want = outcome_q.pop_front();
          bad  = "";
          if (res_i.recognized !== want.recognized) bad = {bad, " recognized"};
          if (res_i.recognized_gesture !== want.recognized_gesture)
            bad = {bad, " recognized_gesture"};
          if (res_i.recognized_mask !== want.recognized_mask) bad = {bad, " recognized_mask"};
          if (res_i.no_match !== want.no_match) bad = {bad, " no_match"};
          if (res_i.session_running !== want.session_running) bad = {bad, " session_running"};
          if (res_i.activation_match !== want.activation_match)
            bad = {bad, " activation_match"};
          if (bad != "")
            note_fault($sformatf(
              "result %0d field(s)%s: exp rec=%0d idx=%0d mask=%h nm=%0d run=%0d act=%0d, got rec=%0d idx=%0d mask=%h nm=%0d run=%0d act=%0d",
              checked_o, bad, want.recognized, want.recognized_gesture,
              want.recognized_mask, want.no_match, want.session_running,
              want.activation_match, res_i.recognized, res_i.recognized_gesture,
              res_i.recognized_mask, res_i.no_match, res_i.session_running,
              res_i.activation_match));
          checked_o++;
          recognized_o += want.recognized;
          eliminated_o += want.no_match;
          act_hits_o   += want.activation_match;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_index_i)
          REG_TOL_1, REG_TOL_2, REG_TOL_3, REG_TOL_4, REG_TOL_5:
            tol_q[cfg_index_i - REG_TOL_1] = cfg_data_i[SAMPLE_BITS-1:0];
          REG_ACT_PAT: act_q    = cfg_data_i[SNAP_W-1:0];
          REG_GCOUNT:  gcount_q = cfg_data_i[GCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) outcome_q.insert(outcome_q.size(), match_outcome(word_i));
    end
    pending_o = outcome_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the gesture matcher bench: clock, reset, command and config stimulus, verdict.
// Depends on tgsm_pkg, tolerant_gesture_sequence_matcher_unit and tgsm_outcome_checker.
module testbench;
  import tgsm_pkg::*;

  typedef logic [FINGERS-1:0][SAMPLE_BITS-1:0] hand_t;

  localparam int ITEMS         = 1950;
  localparam int NUM_PHASES    = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int TAIL_CYCLES   = MAX_GESTURES + 8;
  localparam int FINGER_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int CNT_MAX       = 15;                          // widest step_count in a word
  localparam int GCOUNT_MAX    = (1 << GCOUNT_W) - 1;
  localparam int CMD_LAST_CODE = (1 << $bits(tgsm_cmd_e)) - 1;
  localparam int FAMILIES      = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  tgsm_in_t              in_i;
  logic                  done_o;
  tgsm_out_t             res_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int faults;
  int pending;
  int checked;
  int recognized;
  int eliminated;
  int act_hits;

  int unsigned cycle_cnt = 0;
  int          words_sent = 0;
  logic        idle_on = 1'b1;
  logic        calm = 1'b0;

  // Stimulus-side view of what the block holds, used only to shape words that
  // walk deep into sessions.
  hand_t tmpl_s [MAX_GESTURES][MAX_STEPS];
  int    len_s  [MAX_GESTURES];
  hand_t tol_s;
  hand_t pat_s;
  int    gcount_s;

  tolerant_gesture_sequence_matcher_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tgsm_outcome_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .word_i       (in_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .faults_o     (faults),
    .pending_o    (pending),
    .checked_o    (checked),
    .recognized_o (recognized),
    .eliminated_o (eliminated),
    .act_hits_o   (act_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL tolerant_gesture_sequence_matcher_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------

  function automatic hand_t all_hand(input int v);
    return {FINGERS{SAMPLE_BITS'(v)}};
  endfunction

  // Random hand with the extremes of each finger well represented.
  function automatic hand_t rand_hand();
    hand_t h;
    int    r;
    for (int f = 0; f < FINGERS; f++) begin
      r = $urandom_range(7, 0);
      if (r == 0) h[f] = '0;
      else if (r == 1) h[f] = SAMPLE_BITS'(FINGER_MAX);
      else h[f] = SAMPLE_BITS'($urandom_range(FINGER_MAX, 0));
    end
    return h;
  endfunction

  // Hand close to a reference under the current tolerances: mostly inside the
  // window, often right on its edges, sometimes a dead sensor, and with
  // miss_pct percent per finger just outside the window.
  function automatic hand_t near_hand(input hand_t tpl, input int miss_pct);
    hand_t h;
    int    t;
    int    k;
    int    lo;
    int    hi;
    int    r;
    for (int f = 0; f < FINGERS; f++) begin
      t  = tpl[f];
      k  = tol_s[f];
      lo = (t > k) ? t - k : 0;
      hi = (t + k < FINGER_MAX) ? t + k : FINGER_MAX;
      r  = $urandom_range(99, 0);
      if (r < 6) h[f] = '0;
      else if (r < 14) h[f] = SAMPLE_BITS'(hi);
      else if (r < 22) h[f] = SAMPLE_BITS'(lo);
      else if (r < 22 + miss_pct)
        h[f] = SAMPLE_BITS'((t + k < FINGER_MAX) ? t + k + 1 : (t > k) ? t - k - 1 : t);
      else h[f] = SAMPLE_BITS'($urandom_range(hi, lo));
    end
    return h;
  endfunction

  // Fields a command does not use still carry random bits.
  function automatic tgsm_in_t word_of(input logic [2:0] cmd, input hand_t h);
    tgsm_in_t w;
    w.command       = cmd;
    w.gesture_index = 4'($urandom);
    w.step_index    = 3'($urandom);
    w.step_count    = 4'($urandom);
    {w.finger_five, w.finger_four, w.finger_three, w.finger_two, w.finger_one} = h;
    return w;
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 5) return 0;
    if (r < 65) return $urandom_range(4, 1);
    if (r < 90) return $urandom_range(MAX_STEPS, 5);
    return $urandom_range(CNT_MAX, MAX_STEPS + 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers: change inputs on the falling edge, wait for the handshake
  // on the rising edge.
  // ---------------------------------------------------------------------------

  task automatic send(input tgsm_in_t w);
    int gap;
    gap = 0;
    if (idle_on && !calm && $urandom_range(3, 0) == 0) gap = $urandom_range(13, 1);
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i    = w;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    // Drop start; a word sent right after raises it again in this same step.
    start_i = 1'b0;
    words_sent++;
    if ($urandom_range(39, 0) == 0) idle_on = !idle_on;
  endtask

  task automatic issue(input logic [2:0] cmd, input hand_t h);
    send(word_of(cmd, h));
  endtask

  task automatic put_step(input int g, input int s, input hand_t h);
    tgsm_in_t w;
    w               = word_of(CMD_WR_STEP, h);
    w.gesture_index = 4'(g);
    w.step_index    = 3'(s);
    send(w);
    tmpl_s[g][s] = h;
  endtask

  task automatic put_len(input int g, input int cnt);
    tgsm_in_t w;
    w               = word_of(CMD_WR_LEN, rand_hand());
    w.gesture_index = 4'(g);
    w.step_count    = 4'(cnt);
    send(w);
    len_s[g] = (cnt > MAX_STEPS) ? MAX_STEPS : cnt;
  endtask

  task automatic set_reg(input tgsm_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Write every register, but only once all results are back and the block is idle.
  task automatic apply_setting(input hand_t tol, input hand_t pat, input int cnt);
    while (pending != 0) @(negedge clk_i);
    for (int f = 0; f < FINGERS; f++)
      set_reg(tgsm_reg_e'(REG_TOL_1 + f), CFG_DATA_W'(tol[f]));
    set_reg(REG_ACT_PAT, CFG_DATA_W'(pat));
    set_reg(REG_GCOUNT, CFG_DATA_W'(cnt));
    tol_s    = tol;
    pat_s    = pat;
    gcount_s = cnt;
  endtask

  // Per-phase register setting; the first phases hit the extremes.
  task automatic phase_setting(input int p);
    hand_t tol;
    hand_t pat;
    int    cnt;
    int    r;
    pat = rand_hand();
    cnt = MAX_GESTURES;
    for (int f = 0; f < FINGERS; f++) tol[f] = SAMPLE_BITS'($urandom_range(150, 0));
    case (p)
      0: tol = {FINGERS{TOL_RESET}};
      1: tol = '0;
      2: begin
        tol = '1;
        pat = '1;
        cnt = GCOUNT_MAX;
      end
      3: begin
        pat = '0;
        cnt = $urandom_range(MAX_GESTURES, 1);
      end
      4: begin
        for (int f = 0; f < FINGERS; f++) begin
          r = $urandom_range(2, 0);
          if (r == 0) tol[f] = '0;
          else if (r == 1) tol[f] = '1;
          else tol[f] = SAMPLE_BITS'($urandom_range(FINGER_MAX, 0));
        end
        cnt = $urandom_range(GCOUNT_MAX, MAX_GESTURES + 1);
      end
      default: ;
    endcase
    apply_setting(tol, pat, cnt);
  endtask

  // ---------------------------------------------------------------------------
  // Sequences
  // ---------------------------------------------------------------------------

  // Stray word that may land inside a session: template or length rewrite,
  // activation check, unknown command, or a restart.
  task automatic side_word();
    int r;
    int g;
    int s;
    r = $urandom_range(4, 0);
    g = $urandom_range(MAX_GESTURES - 1, 0);
    s = $urandom_range(MAX_STEPS - 1, 0);
    case (r)
      0: put_step(g, s, near_hand(tmpl_s[g][s], 10));
      1: put_len(g, rand_len());
      2: issue(CMD_ACT_CHECK, ($urandom_range(1, 0) == 0) ? near_hand(pat_s, 3)
                                                           : rand_hand());
      3: issue(3'($urandom_range(CMD_LAST_CODE, CMD_ACT_CHECK + 1)), rand_hand());
      default: issue(CMD_START, rand_hand());
    endcase
  endtask

  // Start a session and walk one live gesture step by step with samples close
  // to its template; neighbors in the same family often follow along.
  task automatic run_session();
    int n;
    int tgt;
    int cand [$];
    if ($urandom_range(3, 0) == 0) put_len($urandom_range(MAX_GESTURES - 1, 0), rand_len());
    n = (gcount_s > MAX_GESTURES) ? MAX_GESTURES : gcount_s;
    for (int g = 0; g < n; g++)
      if (len_s[g] != 0) cand.insert(cand.size(), g);
    issue(CMD_START, rand_hand());
    if (cand.size() == 0) return;
    tgt = cand[$urandom_range(cand.size() - 1, 0)];
    for (int k = 0; k < len_s[tgt]; k++) begin
      if ($urandom_range(19, 0) == 0) side_word();
      issue(CMD_SAMPLE, near_hand(tmpl_s[tgt][k], 2));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int rand_base;
    int r;

    start_i     = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_TOL_1;
    cfg_data_i  = '0;
    for (int g = 0; g < MAX_GESTURES; g++) len_s[g] = 0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. Hold reset-like values but write them explicitly, with no
    // gestures counted in.
    apply_setting({FINGERS{TOL_RESET}}, '0, 0);
    issue(CMD_START, rand_hand());               // nothing alive: ends at once
    issue(CMD_SAMPLE, rand_hand());              // no session: ignored
    issue(CMD_ACT_CHECK, all_hand(0));           // all sensors dead: matches
    issue(CMD_ACT_CHECK, all_hand(FINGER_MAX));  // far off pattern
    issue(CMD_ACT_CHECK, all_hand(TOL_RESET));   // exactly on tolerance
    issue(CMD_ACT_CHECK, {SAMPLE_BITS'(0), SAMPLE_BITS'(0), SAMPLE_BITS'(TOL_RESET + 1),
                          SAMPLE_BITS'(0), SAMPLE_BITS'(0)});  // one finger just over
    for (int c = CMD_ACT_CHECK + 1; c <= CMD_LAST_CODE; c++) issue(3'(c), rand_hand());
    for (int s = 0; s < MAX_STEPS; s++)
      put_step(0, s, (s == 0) ? all_hand(0)
                   : (s == MAX_STEPS - 1) ? all_hand(FINGER_MAX) : rand_hand());
    put_len(0, CNT_MAX);                         // saturates to full length

    // Oversized gesture count; only gesture 0 has a length, the rest are empty.
    apply_setting({FINGERS{TOL_RESET}}, '0, GCOUNT_MAX);
    issue(CMD_START, rand_hand());
    issue(CMD_SAMPLE, all_hand(TOL_RESET));      // edge of window around zero template
    put_len(0, 2);                               // shrink while the session runs
    issue(CMD_START, rand_hand());               // restart while open
    issue(CMD_SAMPLE, all_hand(TOL_RESET + 1));  // just outside: session eliminated

    // Random part, one register setting per phase.
    rand_base = words_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_setting(p);
      calm = (p == NUM_PHASES - 1);
      if (p == 0) begin
        // Fill every template entry so no session ever reads an unwritten one.
        // Gestures past the first few are mostly noisy copies of a family base,
        // so several of them stay alive together and can finish on one sample.
        for (int g = 0; g < MAX_GESTURES; g++)
          for (int s = 0; s < MAX_STEPS; s++)
            put_step(g, s, (g < FAMILIES || $urandom_range(2, 0) == 0)
                           ? rand_hand() : near_hand(tmpl_s[g % FAMILIES][s], 0));
        for (int g = 0; g < MAX_GESTURES; g++) put_len(g, rand_len());
      end
      while (words_sent - rand_base < (p + 1) * ITEMS / NUM_PHASES) begin
        r = $urandom_range(99, 0);
        if (r < 72) run_session();
        else if (r < 82) issue(CMD_SAMPLE, rand_hand());
        else side_word();
      end
    end

    // Drain: every expectation met, then give any stray result time to show.
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d command words over %0d register settings; %0d results checked.",
             words_sent, NUM_PHASES, checked);
    $display("Sessions ended by recognition %0d, by elimination %0d; activation hits %0d.",
             recognized, eliminated, act_hits);
    if (faults == 0) begin
      $display("PASS tolerant_gesture_sequence_matcher_unit");
    end else begin
      $display("%0d mismatching result words", faults);
      $display("FAIL tolerant_gesture_sequence_matcher_unit");
    end
    $finish;
  end

endmodule
